[hw/rtl/ads_pkg.sv]
// shared constants, register codes and the square root step for the disc shader
// no dependencies; imported by every module of the block
package ads_pkg;

  // largest texture edge the datapath is sized for
  localparam int MAX_SIZE = 1024;

  // field widths
  localparam int TEX_W   = 11;
  localparam int PIX_W   = 10;
  localparam int COLOR_W = 8;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_TEX_SIZE    = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_RED   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_GREEN = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_BLUE  = 4'd3;

  localparam logic [TEX_W-1:0]   TEX_SIZE_RST = 11'd64;
  localparam logic [COLOR_W-1:0] COLOR_RST    = 8'd255;
  localparam logic [TEX_W-1:0]   TEX_SIZE_MAX = TEX_W'(MAX_SIZE);

  // offset and sum of squares, in half pixels
  localparam int OFS_W      = PIX_W + 2;
  localparam int SQR_W      = 2 * OFS_W - 2;
  localparam int SUM_W      = SQR_W + 1;
  localparam int FRAC_SHIFT = 14;

  // square root: radicand padded to an even width
  localparam int RAD_RAW_W  = SUM_W + FRAC_SHIFT;
  localparam int RAD_W      = RAD_RAW_W + (RAD_RAW_W % 2);
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int SQ_PER_STG = 2;
  localparam int SQ_STG     = (ROOT_W + SQ_PER_STG - 1) / SQ_PER_STG;

  // edge ramp
  localparam int E_W       = 21;
  localparam int E_LO_W    = 9;
  localparam int ALPHA_W   = 17;
  localparam int EDGE_FULL = 384;
  localparam int RAMP_INT  = 170;
  localparam int RECIP3    = 683;
  localparam int RECIP3_SH = 11;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

  // one partial root in flight
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sq_t;

  // one digit of the restoring square root
  function automatic sq_t sq_step(input sq_t a);
    sq_t b;
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    cur   = {a.rem, a.rad[RAD_W-1 -: 2]};
    trial = {{(REM_W-ROOT_W){1'b0}}, a.root, 2'b01};
    b.rad = {a.rad[RAD_W-3:0], 2'b00};
    if (cur >= trial) begin
      b.rem  = REM_W'(cur - trial);
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = REM_W'(cur);
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

endpackage

[hw/rtl/ads_front.sv]
// front stages: centre offset, squares, scaled sum of squares
// depends on ads_pkg
module ads_front import ads_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_stall,
  input  logic [PIX_W-1:0] in_x,
  input  logic [PIX_W-1:0] in_y,
  input  logic [TEX_W-1:0] s_sat,
  output logic             out_vld,
  input  logic             out_stall,
  output logic [RAD_W-1:0] out_rad
);

  logic                    v0_r, v1_r, v2_r;
  logic                    en0, en1, en2;
  logic signed [OFS_W-1:0] ox_r, oy_r, ox_nxt, oy_nxt;
  logic [SQR_W-1:0]        sx_r, sy_r;
  logic [2*OFS_W-1:0]      px_full, py_full;
  logic [RAD_W-1:0]        rad_r, rad_nxt;

  // stall chain, last stage first
  assign en2      = !v2_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;
  assign out_vld  = v2_r;
  assign out_rad  = rad_r;

  // offset of the pixel centre in half pixels
  assign ox_nxt = $signed({1'b0, in_x, 1'b1}) - $signed({1'b0, s_sat});
  assign oy_nxt = $signed({1'b0, in_y, 1'b1}) - $signed({1'b0, s_sat});

  // squares and scaled sum
  assign px_full = ox_r * ox_r;
  assign py_full = oy_r * oy_r;
  assign rad_nxt = RAD_W'({({1'b0, sx_r} + {1'b0, sy_r}), {FRAC_SHIFT{1'b0}}});

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_vld;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (en0 && in_vld) begin
      ox_r <= ox_nxt;
      oy_r <= oy_nxt;
    end
    if (en1 && v0_r) begin
      sx_r <= px_full[SQR_W-1:0];
      sy_r <= py_full[SQR_W-1:0];
    end
    if (en2 && v1_r) begin
      rad_r <= rad_nxt;
    end
  end

endmodule

[hw/rtl/ads_sqrt.sv]
// pipelined restoring square root, two root bits per stage and one in the last
// depends on ads_pkg (sq_t, sq_step)
module ads_sqrt import ads_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  output logic              in_stall,
  input  logic [RAD_W-1:0]  in_rad,
  output logic              out_vld,
  input  logic              out_stall,
  output logic [ROOT_W-1:0] out_root
);

  logic [SQ_STG-1:0] vld_r;
  logic [SQ_STG:0]   stall_c;
  sq_t               st_r [SQ_STG];

  assign stall_c[SQ_STG] = out_stall;
  assign in_stall        = stall_c[0];
  assign out_vld         = vld_r[SQ_STG-1];
  assign out_root        = st_r[SQ_STG-1].root;

  for (genvar k = 0; k < SQ_STG; k++) begin : g_stg
    logic en;
    logic src_vld;
    sq_t  src;
    sq_t  st_nxt;

    assign en         = !vld_r[k] || !stall_c[k+1];
    assign stall_c[k] = !en;

    // stage input
    if (k == 0) begin : g_first
      assign src_vld = in_vld;
      assign src     = '{rem: '0, root: '0, rad: in_rad};
    end else begin : g_rest
      assign src_vld = vld_r[k-1];
      assign src     = st_r[k-1];
    end

    // digits of this stage
    always_comb begin
      st_nxt = src;
      for (int j = 0; j < SQ_PER_STG; j++) begin
        if (k * SQ_PER_STG + j < ROOT_W) st_nxt = sq_step(st_nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en && src_vld) st_r[k] <= st_nxt;
    end
  end

endmodule

[hw/rtl/ads_shade.sv]
// back stages: edge distance, alpha ramp, premultiplied color
// depends on ads_pkg
module ads_shade import ads_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_stall,
  input  logic [ROOT_W-1:0]  in_root,
  input  logic [TEX_W-1:0]   s_sat,
  input  logic [COLOR_W-1:0] color_red,
  input  logic [COLOR_W-1:0] color_green,
  input  logic [COLOR_W-1:0] color_blue,
  output logic               out_vld,
  input  logic               out_stall,
  output logic [COLOR_W-1:0] out_red,
  output logic [COLOR_W-1:0] out_green,
  output logic [COLOR_W-1:0] out_blue,
  output logic [COLOR_W-1:0] out_alpha
);

  localparam int PROD_W = COLOR_W + ALPHA_W;
  localparam int Q_W    = 2 * (E_LO_W + 1);

  logic                v0_r, v1_r, v2_r;
  logic                en0, en1, en2;
  logic signed [E_W-1:0] e;
  logic                pos_r, full_r;
  logic [E_LO_W-1:0]   elo_r;
  logic [ALPHA_W-1:0]  alpha_r, alpha_nxt, ramp_int;
  logic [Q_W-1:0]      ramp_q;
  logic [PROD_W-1:0]   pr_red, pr_green, pr_blue, pr_alpha;
  logic [COLOR_W-1:0]  red_r, green_r, blue_r, alpha8_r;

  // stall chain
  assign en2      = !v2_r || !out_stall;
  assign en1      = !v1_r || en2;
  assign en0      = !v0_r || en1;
  assign in_stall = !en0;
  assign out_vld  = v2_r;

  // distance from the edge, radius 128*S - 512 in 1/256 pixel
  assign e = $signed({3'b000, s_sat, 7'b0}) - E_W'(512)
           - $signed({{(E_W-ROOT_W){1'b0}}, in_root});

  // e*512/3 = 170*e + floor(2*e/3)
  assign ramp_int  = ALPHA_W'({{(ALPHA_W-E_LO_W){1'b0}}, elo_r} * ALPHA_W'(RAMP_INT));
  assign ramp_q    = {{(Q_W-E_LO_W-1){1'b0}}, elo_r, 1'b0} * Q_W'(RECIP3);
  assign alpha_nxt = !pos_r ? '0 :
                     full_r ? ALPHA_ONE :
                     ramp_int + ALPHA_W'(ramp_q[Q_W-1:RECIP3_SH]);

  // premultiply
  assign pr_red   = {{ALPHA_W{1'b0}}, color_red}   * {{COLOR_W{1'b0}}, alpha_r};
  assign pr_green = {{ALPHA_W{1'b0}}, color_green} * {{COLOR_W{1'b0}}, alpha_r};
  assign pr_blue  = {{ALPHA_W{1'b0}}, color_blue}  * {{COLOR_W{1'b0}}, alpha_r};
  assign pr_alpha = {{ALPHA_W{1'b0}}, COLOR_RST}   * {{COLOR_W{1'b0}}, alpha_r};

  assign out_red   = red_r;
  assign out_green = green_r;
  assign out_blue  = blue_r;
  assign out_alpha = alpha8_r;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_vld;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
    end
  end

  // data
  always_ff @(posedge clk) begin
    if (en0 && in_vld) begin
      pos_r  <= (e > 0);
      full_r <= (e >= E_W'(EDGE_FULL));
      elo_r  <= e[E_LO_W-1:0];
    end
    if (en1 && v0_r) begin
      alpha_r <= alpha_nxt;
    end
    if (en2 && v1_r) begin
      red_r    <= pr_red[PROD_W-2 -: COLOR_W];
      green_r  <= pr_green[PROD_W-2 -: COLOR_W];
      blue_r   <= pr_blue[PROD_W-2 -: COLOR_W];
      alpha8_r <= pr_alpha[PROD_W-2 -: COLOR_W];
    end
  end

endmodule

[hw/rtl/antialiased_disc_pixel_shader.sv]
// top level of the antialiased disc pixel shader: config registers and pipeline
// depends on ads_pkg, ads_front, ads_sqrt, ads_shade
//
// Takes one pixel word per clock and returns one premultiplied RGBA word per
// clock while neither side stalls, in order, for a filled disc centred in a
// square texture of edge tex_size (values above 1024 act as 1024) with an edge
// ramp of 1.5 pixels. The pipeline has 3 front stages (offset, square, sum),
// 10 square root stages resolving two root bits each (one in the last, 19 in
// all), and 3 shading stages ending in the output register. Each stage holds
// its word under a local stall, so bubbles close up and the input is stalled
// only when every stage is full. cfg_ready is always high; write the registers
// only while no pixel is in flight.
module antialiased_disc_pixel_shader import ads_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_x,
  input  logic [PIX_W-1:0]      in_pixel_y,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COLOR_W-1:0]    out_red,
  output logic [COLOR_W-1:0]    out_green,
  output logic [COLOR_W-1:0]    out_blue,
  output logic [COLOR_W-1:0]    out_alpha,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [TEX_W-1:0]   tex_size_r;
  logic [COLOR_W-1:0] color_red_r, color_green_r, color_blue_r;
  logic [TEX_W-1:0]   s_sat;
  logic               f_vld, f_stall, q_vld, q_stall;
  logic [RAD_W-1:0]   f_rad;
  logic [ROOT_W-1:0]  q_root;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_size_r    <= TEX_SIZE_RST;
      color_red_r   <= COLOR_RST;
      color_green_r <= COLOR_RST;
      color_blue_r  <= COLOR_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TEX_SIZE:    tex_size_r    <= cfg_data[TEX_W-1:0];
        REG_COLOR_RED:   color_red_r   <= cfg_data[COLOR_W-1:0];
        REG_COLOR_GREEN: color_green_r <= cfg_data[COLOR_W-1:0];
        REG_COLOR_BLUE:  color_blue_r  <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // saturated texture size
  assign s_sat = (tex_size_r > TEX_SIZE_MAX) ? TEX_SIZE_MAX : tex_size_r;

  ads_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_valid),
    .in_stall  (in_stall),
    .in_x      (in_pixel_x),
    .in_y      (in_pixel_y),
    .s_sat     (s_sat),
    .out_vld   (f_vld),
    .out_stall (f_stall),
    .out_rad   (f_rad)
  );

  ads_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (f_vld),
    .in_stall  (f_stall),
    .in_rad    (f_rad),
    .out_vld   (q_vld),
    .out_stall (q_stall),
    .out_root  (q_root)
  );

  ads_shade u_shade (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_vld      (q_vld),
    .in_stall    (q_stall),
    .in_root     (q_root),
    .s_sat       (s_sat),
    .color_red   (color_red_r),
    .color_green (color_green_r),
    .color_blue  (color_blue_r),
    .out_vld     (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha)
  );

  // input is held back only through a stalled output
  a_in_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_stall && out_valid))
    else $error("input stalled without an output stall");

  // zero coverage gives a black pixel
  a_zero_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_alpha == '0) |-> (out_red == '0 && out_green == '0 && out_blue == '0))
    else $error("color present at zero alpha");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

[test/ads_pixel_checker.sv]
// result checker for the antialiased disc pixel shader: watches the pixel, result
// and register channels, predicts every result word and compares; depends on ads_pkg
module ads_pixel_checker import ads_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [PIX_W-1:0]      in_pixel_x,
  input  logic [PIX_W-1:0]      in_pixel_y,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [COLOR_W-1:0]    out_red,
  input  logic [COLOR_W-1:0]    out_green,
  input  logic [COLOR_W-1:0]    out_blue,
  input  logic [COLOR_W-1:0]    out_alpha,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    errors,
  output int                    outstanding
);

  localparam int REPORT_LIMIT = 10;
  localparam int FULL_SCALE   = 255;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic [COLOR_W-1:0] alpha;
  } rgba_t;

  // shadow copy of the block's registers
  logic [TEX_W-1:0]   size_q;
  logic [COLOR_W-1:0] red_q;
  logic [COLOR_W-1:0] green_q;
  logic [COLOR_W-1:0] blue_q;

  rgba_t expected_pixels[$];
  rgba_t want;
  rgba_t got;
  int    results_seen;

  // largest root whose square does not exceed v
  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 23; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // premultiplied disc pixel for the current register copy
  function automatic rgba_t shade_pixel(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] py);
    longint          s;
    longint          ox;
    longint          oy;
    longint          dist8;
    longint          margin;
    longint unsigned coverage;
    rgba_t           r;
    s = (size_q > TEX_SIZE_MAX) ? longint'(MAX_SIZE) : longint'(size_q);
    // offsets of the pixel centre in half pixels
    ox = 2 * longint'(px) + 1 - s;
    oy = 2 * longint'(py) + 1 - s;
    // distance to 8 fractional bits, radius minus distance
    dist8  = longint'(floor_sqrt(64'(ox * ox + oy * oy) << 14));
    margin = 128 * s - 512 - dist8;
    // linear ramp over 1.5 pixels, clamped to one
    if (margin <= 0) begin
      coverage = 0;
    end else begin
      coverage = 64'(margin * 512 / 3);
      if (coverage > ALPHA_ONE) coverage = ALPHA_ONE;
    end
    r.red   = COLOR_W'((64'(red_q) * coverage) >> 16);
    r.green = COLOR_W'((64'(green_q) * coverage) >> 16);
    r.blue  = COLOR_W'((64'(blue_q) * coverage) >> 16);
    r.alpha = COLOR_W'((64'(FULL_SCALE) * coverage) >> 16);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      size_q       = TEX_SIZE_RST;
      red_q        = COLOR_RST;
      green_q      = COLOR_RST;
      blue_q       = COLOR_RST;
      errors       = 0;
      results_seen = 0;
      expected_pixels.delete();
      outstanding <= 0;
    end else begin
      // register writes, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TEX_SIZE:    size_q  = cfg_data[TEX_W-1:0];
          REG_COLOR_RED:   red_q   = cfg_data[COLOR_W-1:0];
          REG_COLOR_GREEN: green_q = cfg_data[COLOR_W-1:0];
          REG_COLOR_BLUE:  blue_q  = cfg_data[COLOR_W-1:0];
          default: ;
        endcase
      end
      // accepted pixel word
      if (in_valid && !in_stall) expected_pixels.push_back(shade_pixel(in_pixel_x, in_pixel_y));
      // accepted result word against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{out_red, out_green, out_blue, out_alpha};
        results_seen++;
        if (expected_pixels.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("result %0d with nothing pending: rgba %0d %0d %0d %0d",
                     results_seen, got.red, got.green, got.blue, got.alpha);
        end else begin
          want = expected_pixels.pop_front();
          if (want.red != got.red || want.green != got.green ||
              want.blue != got.blue || want.alpha != got.alpha) begin
            errors++;
            if (errors <= REPORT_LIMIT)
              $display("result %0d mismatch: expected rgba %0d %0d %0d %0d, got %0d %0d %0d %0d",
                       results_seen, want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
          end
        end
      end
      outstanding <= expected_pixels.size();
    end
  end

endmodule

[test/tb_antialiased_disc_pixel_shader.sv]
// testbench top for the antialiased disc pixel shader: clock, reset, pixel and
// register stimulus, receiver stalls and verdict; depends on ads_pkg and ads_pixel_checker
module tb_antialiased_disc_pixel_shader import ads_pkg::*;;

  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 64;
  localparam int IDLE_PCT     = 24;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_CYCLES = 24;
  localparam int QUIET_PHASE  = 3;
  localparam int HOLD_PHASE   = 5;
  localparam int PAUSE_PHASE  = 7;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel_x = '0;
  logic [PIX_W-1:0]      in_pixel_y = '0;
  logic                  out_valid;
  logic                  out_stall  = 1'b0;
  logic [COLOR_W-1:0]    out_red;
  logic [COLOR_W-1:0]    out_green;
  logic [COLOR_W-1:0]    out_blue;
  logic [COLOR_W-1:0]    out_alpha;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic quiet    = 1'b0;
  logic hold_req = 1'b0;
  int   errors;
  int   outstanding;

  antialiased_disc_pixel_shader u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_pixel_x (in_pixel_x),
    .in_pixel_y (in_pixel_y),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_red    (out_red),
    .out_green  (out_green),
    .out_blue   (out_blue),
    .out_alpha  (out_alpha),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  ads_pixel_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_pixel_x  (in_pixel_x),
    .in_pixel_y  (in_pixel_y),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #400000;
    $display("** antialiased_disc_pixel_shader: FAILED **");
    $finish;
  end

  // result side: random stalls, one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_served;
    hold_left   = 0;
    hold_served = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  // offer one pixel word until accepted, then maybe go idle
  task automatic send_pixel(input logic [PIX_W-1:0] x, input logic [PIX_W-1:0] y);
    in_valid   <= 1'b1;
    in_pixel_x <= x;
    in_pixel_y <= y;
    do @(posedge clk); while (in_stall);
    if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < IDLE_PCT);
    end
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // all registers, then a write to an unused index that must be dropped
  task automatic load_config(input logic [TEX_W-1:0] size, input logic [CFG_DATA_W-1:0] red,
                             input logic [CFG_DATA_W-1:0] green,
                             input logic [CFG_DATA_W-1:0] blue);
    write_reg(REG_TEX_SIZE, CFG_DATA_W'(size));
    write_reg(REG_COLOR_RED, red);
    write_reg(REG_COLOR_GREEN, green);
    write_reg(REG_COLOR_BLUE, blue);
    write_reg(CFG_IDX_W'($urandom_range(REG_COLOR_BLUE + 1, (1 << CFG_IDX_W) - 1)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // stop offering and wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // random pixel: mostly inside the texture, often on the rim, sometimes anywhere
  task automatic pick_pixel(input int size, output logic [PIX_W-1:0] x,
                            output logic [PIX_W-1:0] y);
    int span;
    int k;
    logic [PIX_W-1:0] t;
    span = (size < 1) ? 1 : ((size > MAX_SIZE) ? MAX_SIZE : size);
    k = $urandom_range(0, 99);
    if (k < 15) begin
      x = PIX_W'($urandom);
      y = PIX_W'($urandom);
    end else if (k < 45) begin
      // across the edge ramp on a line through the centre
      x = PIX_W'($urandom_range(0, 5));
      y = PIX_W'(span / 2 + $urandom_range(0, 2) - 1);
      if ($urandom_range(0, 1)) x = PIX_W'(span - 1) - x;
      if ($urandom_range(0, 1)) begin
        t = x;
        x = y;
        y = t;
      end
    end else begin
      x = PIX_W'($urandom_range(0, span - 1));
      y = PIX_W'($urandom_range(0, span - 1));
    end
  endtask

  initial begin : stimulus
    logic [PIX_W-1:0]      x;
    logic [PIX_W-1:0]      y;
    logic [CFG_DATA_W-1:0] red;
    logic [CFG_DATA_W-1:0] green;
    logic [CFG_DATA_W-1:0] blue;
    int                    size;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: centre, corners, rim, beyond the texture, field extremes
    send_pixel(32, 32);
    send_pixel(31, 31);
    send_pixel(0, 0);
    send_pixel(63, 63);
    send_pixel(0, 32);
    send_pixel(2, 32);
    send_pixel(3, 32);
    send_pixel(4, 32);
    send_pixel(100, 100);
    send_pixel(1023, 1023);
    drain();

    // oversized edge saturates; color data above the byte is dropped
    load_config(11'h7ff, 11'h700, 11'h080, 11'h7ff);
    send_pixel(512, 512);
    send_pixel(0, 512);
    send_pixel(1, 512);
    send_pixel(1023, 0);
    send_pixel(0, 1023);
    drain();

    // zero and tiny sizes give nothing
    load_config(11'd0, 11'd255, 11'd255, 11'd255);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    drain();
    load_config(11'd3, 11'd200, 11'd100, 11'd50);
    send_pixel(1, 1);
    drain();
    load_config(11'd4, 11'd200, 11'd100, 11'd50);
    send_pixel(1, 1);
    send_pixel(2, 2);
    drain();
    // smallest disc with a partial centre
    load_config(11'd5, 11'd200, 11'd100, 11'd50);
    send_pixel(2, 2);
    drain();

    // random phases, each under its own register setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       size = MAX_SIZE;
        1:       size = 1;
        2:       size = (1 << TEX_W) - 1;
        5:       size = 8;
        8:       size = $urandom_range(MAX_SIZE + 1, (1 << TEX_W) - 2);
        9:       size = 4;
        default: size = $urandom_range(5, MAX_SIZE - 1);
      endcase
      red   = CFG_DATA_W'($urandom);
      green = CFG_DATA_W'($urandom);
      blue  = CFG_DATA_W'($urandom);
      if (phase == 0) begin
        red   = 11'h0ff;
        green = 11'h0ff;
        blue  = 11'h0ff;
      end else if (phase == 1 || phase == 2) begin
        red   = 11'h000;
        green = 11'h700;
        blue  = 11'h0ff;
      end
      load_config(TEX_W'(size), red, green, blue);

      quiet    <= (phase == QUIET_PHASE);
      hold_req <= (phase == HOLD_PHASE);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // sender waits for the pipeline to empty midway
        if (phase == PAUSE_PHASE && n == PHASE_ITEMS / 2) drain();
        pick_pixel(size, x, y);
        send_pixel(x, y);
      end
      drain();
    end

    quiet <= 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** antialiased_disc_pixel_shader: PASSED **");
    end else begin
      $display("** antialiased_disc_pixel_shader: FAILED **");
    end
    $finish;
  end

endmodule
